// ===== sv/grlc_pkg.sv =====
// Shared constants, types and a helper function of the frame-group range cache.
`default_nettype none

package grlc_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int GOP_SPAN      = 64;
    localparam int FRAME_BITS    = 20;
    localparam int MASK_W        = 64;
    localparam int USE_W         = 4;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
    localparam int OFF_W         = $clog2(MASK_W);

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_INSERT = 1'b1
    } kind_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] key;
        logic [FRAME_BITS-1:0] first;
        logic [FRAME_BITS-1:0] last;
        logic [MASK_W-1:0]     present;
    } entry_t;

    typedef struct packed {
        kind_t                 kind;
        logic [FRAME_BITS-1:0] frame;
        entry_t                ent;
    } req_t;

    typedef struct packed {
        logic sample;
        logic shift;
        logic load;
    } cell_ctl_t;

    // Index of the lowest set bit, which is the oldest matching position.
    function automatic logic [IDX_W-1:0] first_set(input logic [CACHE_ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== sv/grlc_req_if.sv =====
// Request channel interface: valid/ready handshake with the lookup or insert payload.
`default_nettype none

interface grlc_req_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [grlc_pkg::FRAME_BITS-1:0] frame_index;
    logic [grlc_pkg::FRAME_BITS-1:0] key_index;
    logic [grlc_pkg::FRAME_BITS-1:0] start_frame;
    logic [grlc_pkg::FRAME_BITS-1:0] end_frame;
    logic [grlc_pkg::MASK_W-1:0]     present_mask;

    modport source (
        output valid, kind, frame_index, key_index, start_frame, end_frame, present_mask,
        input  ready
    );

    modport sink (
        input  valid, kind, frame_index, key_index, start_frame, end_frame, present_mask,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/grlc_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the per-request result.
`default_nettype none

interface grlc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [grlc_pkg::FRAME_BITS-1:0] hit_key;
    logic                            evicted;
    logic [grlc_pkg::FRAME_BITS-1:0] evicted_key;
    logic [grlc_pkg::USE_W-1:0]      entries_in_use;

    modport source (
        output valid, hit, hit_key, evicted, evicted_key, entries_in_use,
        input  ready
    );

    modport sink (
        input  valid, hit, hit_key, evicted, evicted_key, entries_in_use,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/gop_range_lru_cache.sv =====
// Top level of the frame-group range cache: a row of age-ordered cells and its sequencer.
//
// Usage: requests arrive on the req channel and one response leaves on the rsp channel
// for every request, in order. A lookup (kind 0) searches the entries from oldest to
// newest for the first one whose range and presence mask hold frame_index; the hit
// entry becomes the newest and its key is returned. An insert (kind 1) removes an entry
// with the same key, drops the oldest entry when the table is still full, and appends
// the new entry as newest.
// A request taken on the req channel passes the compare step in the cells and then the
// update step, which shifts along the row of cells and registers its response. A new
// request is taken only as the update step of the previous one finishes.
// The response sits in an output register, so a request is taken while an earlier
// response still waits. When the receiver stalls with a response pending, the update
// step waits and the req channel shows not ready until the response has been taken.
// Reset empties the table (entry count zero) and clears the response valid; entry
// contents are not cleared, since positions past the count are never read.
`default_nettype none

module gop_range_lru_cache (
    input  wire logic clk,
    input  wire logic rst_n,
    grlc_req_if.sink   req,
    grlc_rsp_if.source rsp
);

    localparam int N     = grlc_pkg::CACHE_ENTRIES;
    localparam int IDX_W = grlc_pkg::IDX_W;
    localparam int CNT_W = grlc_pkg::CNT_W;
    localparam int FB    = grlc_pkg::FRAME_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    grlc_pkg::req_t       req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     cnt_m1;

    logic                 rsp_valid_reg;
    logic                 rsp_hit_reg;
    logic [FB-1:0]        rsp_hit_key_reg;
    logic                 rsp_evicted_reg;
    logic [FB-1:0]        rsp_evicted_key_reg;
    logic [grlc_pkg::USE_W-1:0] rsp_use_reg;

    grlc_pkg::entry_t     cell_q [N];
    grlc_pkg::cell_ctl_t  cell_ctl [N];
    logic [N-1:0]         lk_hit_vec;
    logic [N-1:0]         key_hit_vec;
    logic [N-1:0]         vmask;
    logic [N-1:0]         lk_vec;
    logic [N-1:0]         key_vec;
    logic [IDX_W-1:0]     lk_idx;
    logic [IDX_W-1:0]     key_idx;
    logic [IDX_W-1:0]     last_idx;

    logic                 in_xfer;
    logic                 out_free;
    logic                 upd_go;
    logic                 do_move;
    logic                 do_load;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     newest;
    grlc_pkg::entry_t     bcast;
    logic                 hit_c;
    logic [FB-1:0]        hit_key_c;
    logic                 ev_c;
    logic [FB-1:0]        ev_key_c;

    // The update step may finish only when the response register is free.
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign upd_go    = (state_reg == ST_UPD) && out_free;
    assign req.ready = (state_reg == ST_IDLE) || upd_go;
    assign in_xfer   = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    state_next = in_xfer ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg.kind        <= grlc_pkg::kind_t'(req.kind);
            req_reg.frame       <= req.frame_index;
            req_reg.ent.key     <= req.key_index;
            req_reg.ent.first   <= req.start_frame;
            req_reg.ent.last    <= req.end_frame;
            req_reg.ent.present <= req.present_mask;
        end
    end

    // Only positions below the count hold live entries.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            vmask[i] = CNT_W'(i) < count_reg;
        end
    end

    assign lk_vec   = lk_hit_vec & vmask;
    assign key_vec  = key_hit_vec & vmask;
    assign lk_idx   = grlc_pkg::first_set(lk_vec);
    assign key_idx  = grlc_pkg::first_set(key_vec);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];

    // Every change is "remove at r_idx, close the gap, place bcast at newest", or a plain
    // append when an insert finds room and no entry with its key.
    always_comb
    begin
        do_move    = 1'b0;
        do_load    = 1'b0;
        r_idx      = '0;
        newest     = '0;
        count_next = count_reg;
        bcast      = req_reg.ent;
        hit_c      = 1'b0;
        hit_key_c  = '0;
        ev_c       = 1'b0;
        ev_key_c   = '0;
        unique case (req_reg.kind)
            grlc_pkg::KIND_LOOKUP:
            begin
                if (|lk_vec)
                begin
                    do_move   = 1'b1;
                    do_load   = 1'b1;
                    r_idx     = lk_idx;
                    newest    = last_idx;
                    bcast     = cell_q[lk_idx];
                    hit_c     = 1'b1;
                    hit_key_c = cell_q[lk_idx].key;
                end
            end
            grlc_pkg::KIND_INSERT:
            begin
                do_load = 1'b1;
                if (|key_vec)
                begin
                    do_move = 1'b1;
                    r_idx   = key_idx;
                    newest  = last_idx;
                end
                else if (count_reg == CNT_W'(N))
                begin
                    do_move  = 1'b1;
                    r_idx    = '0;
                    newest   = IDX_W'(N - 1);
                    ev_c     = 1'b1;
                    ev_key_c = cell_q[0].key;
                end
                else
                begin
                    newest     = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                do_load = 1'b0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            grlc_pkg::entry_t nb_entry;

            always_comb
            begin
                cell_ctl[gi].sample = (state_reg == ST_CMP);
                cell_ctl[gi].shift  = upd_go && do_move && (IDX_W'(gi) >= r_idx)
                                      && (IDX_W'(gi) < newest);
                cell_ctl[gi].load   = upd_go && do_load && (IDX_W'(gi) == newest);
            end

            // The top position (N-1) never shifts, so its neighbor input is not used.
            if (gi == N - 1)
            begin : g_end
                assign nb_entry = bcast;
            end
            else
            begin : g_mid
                assign nb_entry = cell_q[gi + 1];
            end

            grlc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (cell_ctl[gi]),
                .nb      (nb_entry),
                .bcast   (bcast),
                .frame   (req_reg.frame),
                .key     (req_reg.ent.key),
                .q       (cell_q[gi]),
                .lk_hit  (lk_hit_vec[gi]),
                .key_hit (key_hit_vec[gi])
            );
        end
    endgenerate

    // Response register: loaded when the update finishes, cleared by a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (upd_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            rsp_hit_reg         <= hit_c;
            rsp_hit_key_reg     <= hit_key_c;
            rsp_evicted_reg     <= ev_c;
            rsp_evicted_key_reg <= ev_key_c;
            rsp_use_reg         <= grlc_pkg::USE_W'(count_next);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.hit            = rsp_hit_reg;
    assign rsp.hit_key        = rsp_hit_key_reg;
    assign rsp.evicted        = rsp_evicted_reg;
    assign rsp.evicted_key    = rsp_evicted_key_reg;
    assign rsp.entries_in_use = rsp_use_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N))
        else $error("entry count exceeds table size");

    a_rsp_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("response raised outside the update step");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_hit_reg && rsp_evicted_reg))
        else $error("response reports both hit and eviction");

    a_lookup_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && (req_reg.kind == grlc_pkg::KIND_LOOKUP)) |=> $stable(count_reg))
        else $error("lookup changed the entry count");
`endif

endmodule

`default_nettype wire

// ===== sv/grlc_cell.sv =====
// One cache position: holds an entry, matches it against the request, shifts or loads.
`default_nettype none

module grlc_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire grlc_pkg::cell_ctl_t             ctl,
    input  wire grlc_pkg::entry_t                nb,
    input  wire grlc_pkg::entry_t                bcast,
    input  wire logic [grlc_pkg::FRAME_BITS-1:0] frame,
    input  wire logic [grlc_pkg::FRAME_BITS-1:0] key,
    output grlc_pkg::entry_t                     q,
    output logic                                 lk_hit,
    output logic                                 key_hit
);

    grlc_pkg::entry_t                entry_reg;
    logic                            lk_hit_reg;
    logic                            key_hit_reg;
    logic [grlc_pkg::FRAME_BITS-1:0] off;
    logic                            lk_next;
    logic                            key_next;

    // A frame hits when it lies in the range, within the span, and its mask bit is set.
    always_comb
    begin
        off      = frame - entry_reg.first;
        lk_next  = (frame >= entry_reg.first) && (frame <= entry_reg.last)
                   && (off < grlc_pkg::FRAME_BITS'(grlc_pkg::GOP_SPAN))
                   && entry_reg.present[off[grlc_pkg::OFF_W-1:0]];
        key_next = (entry_reg.key == key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_hit_reg  <= 1'b0;
            key_hit_reg <= 1'b0;
        end
        else if (ctl.sample)
        begin
            lk_hit_reg  <= lk_next;
            key_hit_reg <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            entry_reg <= bcast;
        end
        else if (ctl.shift)
        begin
            entry_reg <= nb;
        end
    end

    assign q       = entry_reg;
    assign lk_hit  = lk_hit_reg;
    assign key_hit = key_hit_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_gop_range_lru_cache.sv =====
// Self-checking testbench of the frame-group range cache, driven by directed and random traffic.
`timescale 1ns / 100ps

module tb_gop_range_lru_cache;

    // The idle watchdog allows far more than the longest intended quiet stretch, which
    // is the long receiver hold-off plus the latency of the block.
    localparam int IDLE_LIMIT = 4000;
    // The receiver pattern used in its periodic mode. It is read one bit per cycle.
    localparam logic [12:0] STALL_PATTERN = 13'b1011001110101;

    // Expected outcome of one request, in the order of the response fields.
    typedef struct packed {
        logic                            hit;
        logic [grlc_pkg::FRAME_BITS-1:0] hit_key;
        logic                            evicted;
        logic [grlc_pkg::FRAME_BITS-1:0] evicted_key;
        logic [grlc_pkg::USE_W-1:0]      in_use;
    } cache_result_t;

    typedef enum int {
        RSP_ALWAYS_READY,
        RSP_RANDOM_STALL,
        RSP_PATTERN_STALL
    } rsp_mode_t;

    logic clk;
    logic rst_n;

    grlc_req_if req_ch ();
    grlc_rsp_if rsp_ch ();

    gop_range_lru_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the table. Position 0 is the oldest entry, and position
    // shadow_fill-1 is the newest.
    grlc_pkg::entry_t shadow_tbl [grlc_pkg::CACHE_ENTRIES];
    int               shadow_fill;
    cache_result_t    pending_results [$];

    int               err_count;
    int               idle_cycles;
    rsp_mode_t        rsp_mode;
    int               hold_left;
    logic [grlc_pkg::FRAME_BITS-1:0] window_base;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Closes the gap at position pos, so that the younger entries each move one place older.
    function automatic void remove_slot(input int pos);
        for (int j = pos; j < shadow_fill - 1; j++)
        begin
            shadow_tbl[j] = shadow_tbl[j + 1];
        end
        shadow_fill--;
    endfunction

    // Applies one request to the shadow table and returns the response it must cause.
    function automatic cache_result_t cache_predict(
        input grlc_pkg::kind_t                 k,
        input logic [grlc_pkg::FRAME_BITS-1:0] frame,
        input grlc_pkg::entry_t                ent);
        cache_result_t                   res;
        grlc_pkg::entry_t                moved;
        logic [grlc_pkg::FRAME_BITS-1:0] off;
        bit                              found;
        int                              i;
        res   = '0;
        found = 1'b0;
        if (k == grlc_pkg::KIND_LOOKUP)
        begin
            // The oldest entry that holds the frame wins. A frame past the span of
            // the mask counts as absent, even when the range covers it.
            for (i = 0; i < shadow_fill && !found; i++)
            begin
                off = frame - shadow_tbl[i].first;
                if (frame >= shadow_tbl[i].first && frame <= shadow_tbl[i].last &&
                    off < grlc_pkg::GOP_SPAN &&
                    shadow_tbl[i].present[off[grlc_pkg::OFF_W-1:0]])
                begin
                    moved = shadow_tbl[i];
                    remove_slot(i);
                    shadow_tbl[shadow_fill] = moved;
                    shadow_fill++;
                    res.hit     = 1'b1;
                    res.hit_key = moved.key;
                    found       = 1'b1;
                end
            end
        end
        else
        begin
            // Entries with the same key go first, so a replacement never evicts.
            i = 0;
            while (i < shadow_fill)
            begin
                if (shadow_tbl[i].key == ent.key)
                begin
                    remove_slot(i);
                end
                else
                begin
                    i++;
                end
            end
            if (shadow_fill >= grlc_pkg::CACHE_ENTRIES)
            begin
                res.evicted     = 1'b1;
                res.evicted_key = shadow_tbl[0].key;
                remove_slot(0);
            end
            shadow_tbl[shadow_fill] = ent;
            shadow_fill++;
        end
        res.in_use = grlc_pkg::USE_W'(shadow_fill);
        return res;
    endfunction

    // Offers one request from the falling edge on and holds it until the transfer.
    // Valid is never lowered here, so back-to-back calls keep it high without a glitch.
    task automatic send_request(input grlc_pkg::kind_t k,
                                input logic [grlc_pkg::FRAME_BITS-1:0] frame,
                                input logic [grlc_pkg::FRAME_BITS-1:0] key,
                                input logic [grlc_pkg::FRAME_BITS-1:0] first,
                                input logic [grlc_pkg::FRAME_BITS-1:0] last,
                                input logic [grlc_pkg::MASK_W-1:0] mask);
        grlc_pkg::entry_t ent;
        cache_result_t    exp_res;
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= k;
        req_ch.frame_index  <= frame;
        req_ch.key_index    <= key;
        req_ch.start_frame  <= first;
        req_ch.end_frame    <= last;
        req_ch.present_mask <= mask;
        do
        begin
            @(posedge clk);
        end
        while (req_ch.ready !== 1'b1);
        ent.key         = key;
        ent.first       = first;
        ent.last        = last;
        ent.present     = mask;
        exp_res         = cache_predict(k, frame, ent);
        pending_results = {pending_results, exp_res};
    endtask

    // Lowers valid for a number of cycles and puts junk on the payload meanwhile.
    task automatic idle_sender(input int cycles);
        @(negedge clk);
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= 1'($urandom_range(0, 1));
        req_ch.frame_index  <= grlc_pkg::FRAME_BITS'($urandom());
        req_ch.key_index    <= grlc_pkg::FRAME_BITS'($urandom());
        req_ch.start_frame  <= grlc_pkg::FRAME_BITS'($urandom());
        req_ch.end_frame    <= grlc_pkg::FRAME_BITS'($urandom());
        req_ch.present_mask <= {$urandom(), $urandom()};
        repeat (cycles) @(posedge clk);
    endtask

    // Holds the sender back until every outstanding response has come.
    task automatic pause_until_drained();
        idle_sender(1);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Lookups on an empty table, the extremes of the frame and key fields, a frame
    // past the mask span, an empty range, a replacement of a key, and eviction from
    // a full table, followed by a replacement that must not evict.
    task automatic test_directed();
        send_request(grlc_pkg::KIND_LOOKUP, '0, '1, '1, '0, '1);
        send_request(grlc_pkg::KIND_LOOKUP, '1, '0, '0, '1, '0);
        send_request(grlc_pkg::KIND_INSERT, '1, '0, '0, '1, '1);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd0, '1, '0, '0, '0);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd63, '0, '1, '1, '1);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd64, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_INSERT, '0, '1, 20'hFFFC0, '1, 64'h8000_0000_0000_0000);
        send_request(grlc_pkg::KIND_LOOKUP, '1, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_LOOKUP, 20'hFFFFE, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_INSERT, '0, 20'd5, 20'd100, 20'd90, '1);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd95, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd100, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_INSERT, '0, '0, 20'd200, 20'd263,
                     64'hAAAA_AAAA_AAAA_AAAA);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd201, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd200, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd0, '0, '0, '0, '0);
        send_request(grlc_pkg::KIND_INSERT, '0, 20'd10, 20'd300, 20'd320, '0);
        for (int k = 11; k <= 14; k++)
        begin
            send_request(grlc_pkg::KIND_INSERT, '0, grlc_pkg::FRAME_BITS'(k),
                         grlc_pkg::FRAME_BITS'(k * 16),
                         grlc_pkg::FRAME_BITS'(k * 16 + 15), 64'h0000_0000_0000_FFFF);
        end
        // The table is full here, so the oldest entry goes.
        send_request(grlc_pkg::KIND_INSERT, '0, 20'd15, 20'd500, 20'd563, '1);
        send_request(grlc_pkg::KIND_INSERT, '0, 20'd15, 20'd600, 20'd610, '1);
        send_request(grlc_pkg::KIND_LOOKUP, 20'd605, '0, '0, '0, '0);
        idle_sender($urandom_range(1, 5));
    endtask

    // Random traffic. Most requests are well formed: a small pool of keys so that keys
    // repeat and entries are evicted, ranges within a small window, and lookups aimed at
    // frames of entries that the table holds. The rest is noise over the whole field width.
    task automatic test_random_traffic(input int count, input bit with_gaps);
        grlc_pkg::kind_t                 k;
        logic [grlc_pkg::FRAME_BITS-1:0] frame;
        logic [grlc_pkg::FRAME_BITS-1:0] key;
        logic [grlc_pkg::FRAME_BITS-1:0] first;
        logic [grlc_pkg::FRAME_BITS-1:0] last;
        logic [grlc_pkg::MASK_W-1:0]     mask;
        int                              burst_left;
        int                              pick;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (with_gaps && burst_left == 0)
            begin
                idle_sender($urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if ($urandom_range(0, 99) < 15)
            begin
                k     = grlc_pkg::kind_t'($urandom_range(0, 1));
                frame = grlc_pkg::FRAME_BITS'($urandom());
                key   = grlc_pkg::FRAME_BITS'($urandom());
                first = grlc_pkg::FRAME_BITS'($urandom());
                last  = grlc_pkg::FRAME_BITS'($urandom());
                mask  = {$urandom(), $urandom()};
            end
            else
            begin
                k     = ($urandom_range(0, 9) < 4) ? grlc_pkg::KIND_INSERT
                                                   : grlc_pkg::KIND_LOOKUP;
                key   = ($urandom_range(0, 9) == 0)
                        ? grlc_pkg::FRAME_BITS'($urandom())
                        : grlc_pkg::FRAME_BITS'($urandom_range(0, 11));
                first = window_base + grlc_pkg::FRAME_BITS'($urandom_range(0, 400));
                if ($urandom_range(0, 15) == 0)
                begin
                    last = first - grlc_pkg::FRAME_BITS'($urandom_range(1, 10));
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    last = first + grlc_pkg::FRAME_BITS'($urandom_range(0, 200));
                end
                else
                begin
                    last = first + grlc_pkg::FRAME_BITS'($urandom_range(0, 63));
                end
                case ($urandom_range(0, 3))
                    0: mask = '1;
                    1: mask = {$urandom(), $urandom()} & {$urandom(), $urandom()} &
                              {$urandom(), $urandom()};
                    default: mask = {$urandom(), $urandom()};
                endcase
                if (shadow_fill > 0 && $urandom_range(0, 9) < 7)
                begin
                    pick  = $urandom_range(0, shadow_fill - 1);
                    frame = shadow_tbl[pick].first
                            + grlc_pkg::FRAME_BITS'($urandom_range(0, 70));
                end
                else
                begin
                    frame = window_base + grlc_pkg::FRAME_BITS'($urandom_range(0, 500));
                end
            end
            send_request(k, frame, key, first, last, mask);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering requests,
    // so the output register fills and the block stalls its request channel.
    task automatic test_output_stall();
        rsp_mode  = RSP_ALWAYS_READY;
        hold_left = 300;
        test_random_traffic(40, 1'b0);
    endtask

    // Traffic with a pause in the middle that waits for every response to arrive.
    task automatic test_drain_pause();
        rsp_mode = RSP_RANDOM_STALL;
        test_random_traffic(30, 1'b1);
        pause_until_drained();
        test_random_traffic(30, 1'b1);
    endtask

    // Receiver. It changes ready at the falling edge. The long hold-off is counted
    // down here, and the stall pattern depends on the mode of the current phase.
    initial
    begin
        int pat_pos;
        pat_pos      = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pat_pos = (pat_pos + 1) % 13;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (rsp_mode)
                    RSP_RANDOM_STALL:  rsp_ch.ready <= ($urandom_range(0, 2) != 0);
                    RSP_PATTERN_STALL: rsp_ch.ready <= STALL_PATTERN[pat_pos];
                    default:           rsp_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Response checker. Every transfer on the response channel is compared field by
    // field with the oldest expectation.
    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected response", 64'(rsp_ch.entries_in_use), '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.hit !== want.hit)
                begin
                    report_mismatch("hit", 64'(rsp_ch.hit), 64'(want.hit));
                end
                if (rsp_ch.hit_key !== want.hit_key)
                begin
                    report_mismatch("hit_key", 64'(rsp_ch.hit_key), 64'(want.hit_key));
                end
                if (rsp_ch.evicted !== want.evicted)
                begin
                    report_mismatch("evicted", 64'(rsp_ch.evicted), 64'(want.evicted));
                end
                if (rsp_ch.evicted_key !== want.evicted_key)
                begin
                    report_mismatch("evicted_key", 64'(rsp_ch.evicted_key),
                                    64'(want.evicted_key));
                end
                if (rsp_ch.entries_in_use !== want.in_use)
                begin
                    report_mismatch("entries_in_use", 64'(rsp_ch.entries_in_use),
                                    64'(want.in_use));
                end
            end
        end
    end

    // Watchdog. It counts the cycles in which neither channel moves a transfer and ends
    // the run when the block has clearly stopped.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence. Reset is applied once, then the tests run in turn with the
    // receiver in different stall modes, and finally the run drains and reports.
    initial
    begin
        err_count           = 0;
        idle_cycles         = 0;
        hold_left           = 0;
        shadow_fill         = 0;
        window_base         = '0;
        rsp_mode            = RSP_RANDOM_STALL;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = grlc_pkg::KIND_LOOKUP;
        req_ch.frame_index  = '0;
        req_ch.key_index    = '0;
        req_ch.start_frame  = '0;
        req_ch.end_frame    = '0;
        req_ch.present_mask = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        test_directed();

        // A stretch without any idling on either side.
        rsp_mode = RSP_ALWAYS_READY;
        test_random_traffic(120, 1'b0);

        rsp_mode = RSP_RANDOM_STALL;
        test_random_traffic(150, 1'b1);

        // The same traffic near the top of the frame numbers.
        rsp_mode    = RSP_PATTERN_STALL;
        window_base = 20'hFFD00;
        test_random_traffic(150, 1'b1);
        window_base = '0;

        test_output_stall();
        test_drain_pause();

        rsp_mode = RSP_PATTERN_STALL;
        test_random_traffic(80, 1'b0);

        pause_until_drained();
        repeat (6) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== gop_range_lru_cache.f =====
sv/grlc_pkg.sv
sv/grlc_req_if.sv
sv/grlc_rsp_if.sv
sv/grlc_cell.sv
sv/gop_range_lru_cache.sv
tb/sv/tb_gop_range_lru_cache.sv
